// File: rtl/core/sdq_pkg.sv
`default_nettype none
package sdq_pkg;

	localparam int VALUE_W  = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP_MIN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_POP_MAX = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Operation broadcast to every cell in a cycle.
	typedef struct packed {
		logic                      ins;
		logic                      pop_min;
		logic                      pop_max;
		logic signed [VALUE_W-1:0] value;
	} sdq_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/sdq_req_if.sv
`default_nettype none
interface sdq_req_if import sdq_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sdq_rsp_if.sv
`default_nettype none
interface sdq_rsp_if import sdq_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] result_value;
	logic [STATUS_W-1:0]       status;

	modport source (output valid, output result_value, output status, input ready);
	modport sink (input valid, input result_value, input status, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sdq_cell.sv
`default_nettype none
module sdq_cell import sdq_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sdq_ctrl_t                 ctrl,
	input  logic signed [VALUE_W-1:0] left_val,
	input  logic                      left_vld,
	input  logic                      left_less,
	input  logic signed [VALUE_W-1:0] right_val,
	input  logic                      right_vld,
	output logic signed [VALUE_W-1:0] val,
	output logic                      vld,
	output logic                      less,
	output logic                      sel_max
);

	logic signed [VALUE_W-1:0] val_q;
	logic                      vld_q;
	logic signed [VALUE_W-1:0] val_d;
	logic                      vld_d;

	// entries are sorted, so less forms a prefix of the row
	assign less    = vld_q && (val_q < ctrl.value);
	assign sel_max = vld_q && !right_vld;
	assign val     = val_q;
	assign vld     = vld_q;

	always_comb begin
		val_d = val_q;
		vld_d = vld_q;
		if (ctrl.ins) begin
			if (!less) begin
				// boundary cell takes the new value, cells above shift right
				val_d = left_less ? ctrl.value : left_val;
				vld_d = vld_q | left_vld;
			end
		end else if (ctrl.pop_min) begin
			val_d = right_val;
			vld_d = right_vld;
		end else if (ctrl.pop_max) begin
			vld_d = vld_q & right_vld;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/sorted_double_ended_queue.sv
// Sorted double-ended queue: holds up to CAPACITY signed 32-bit values in
// ascending order in a row of cells, each cell one entry plus an occupancy
// bit; the occupied cells always form a prefix of the row.
// Channel req (sink): kind (insert, remove smallest, remove largest) and
// value. Channel rsp (source): result_value and status (ok, empty, full).
// Every req transaction gives exactly one rsp transaction.
// The result is registered and shows the cycle after the req transaction.
// Throughput: one transaction per cycle while rsp.ready is high; every cell
// compares against the broadcast value and shifts with its neighbour in
// that cycle. Back-pressure: req.ready is high while the output register is
// empty or being drained in the same cycle; while rsp.ready is low with a
// result waiting, no new transaction is taken and the store holds.
// Reset (arst_n low): all cells empty, no result pending. Cell contents
// are not cleared, only the occupancy bits.
// Insert into a full store and removal from an empty one change nothing
// and report full or empty with a zero value; the unused kind code is
// answered ok with zero.
`default_nettype none
module sorted_double_ended_queue import sdq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	sdq_req_if.sink    req,
	sdq_rsp_if.source  rsp
);

	// neighbour nets; index CAPACITY is the empty slot past the last cell
	logic signed [VALUE_W-1:0] cell_val [CAPACITY+1];
	logic                      cell_vld [CAPACITY+1];
	logic                      cell_less [CAPACITY];
	logic                      cell_sel [CAPACITY];

	logic                      rsp_valid_q;
	logic signed [VALUE_W-1:0] rsp_value_q;
	logic [STATUS_W-1:0]       rsp_status_q;

	logic                      accept;
	logic                      full;
	logic                      empty;
	logic signed [VALUE_W-1:0] max_val;
	logic signed [VALUE_W-1:0] res_val;
	logic [STATUS_W-1:0]       res_status;
	sdq_ctrl_t                 ctrl;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full  = cell_vld[CAPACITY-1];
	assign empty = !cell_vld[0];

	assign cell_val[CAPACITY] = '0;
	assign cell_vld[CAPACITY] = 1'b0;

	// decode; operations that cannot proceed leave the row untouched
	always_comb begin
		ctrl.value   = req.value;
		ctrl.ins     = accept && (req.kind == KIND_INSERT) && !full;
		ctrl.pop_min = accept && (req.kind == KIND_POP_MIN) && !empty;
		ctrl.pop_max = accept && (req.kind == KIND_POP_MAX) && !empty;
	end

	// largest value: in a non-empty store exactly one occupied cell has an empty right neighbour
	always_comb begin
		max_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			max_val = max_val | (cell_sel[i] ? cell_val[i] : '0);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] l_val;
		logic                      l_vld;
		logic                      l_less;

		if (i == 0) begin : g_first
			// first cell: new value always lands here if it is not less
			assign l_val  = '0;
			assign l_vld  = 1'b1;
			assign l_less = 1'b1;
		end else begin : g_rest
			assign l_val  = cell_val[i-1];
			assign l_vld  = cell_vld[i-1];
			assign l_less = cell_less[i-1];
		end

		sdq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.left_val  (l_val),
			.left_vld  (l_vld),
			.left_less (l_less),
			.right_val (cell_val[i+1]),
			.right_vld (cell_vld[i+1]),
			.val       (cell_val[i]),
			.vld       (cell_vld[i]),
			.less      (cell_less[i]),
			.sel_max   (cell_sel[i])
		);
	end

	always_comb begin
		res_val    = '0;
		res_status = ST_OK;
		unique case (req.kind)
			KIND_INSERT: begin
				if (full) begin
					res_status = ST_FULL;
				end else begin
					res_val = req.value;
				end
			end
			KIND_POP_MIN: begin
				if (empty) begin
					res_status = ST_EMPTY;
				end else begin
					res_val = cell_val[0];
				end
			end
			KIND_POP_MAX: begin
				if (empty) begin
					res_status = ST_EMPTY;
				end else begin
					res_val = max_val;
				end
			end
			default: begin
				res_val    = '0;
				res_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_value_q  <= res_val;
			rsp_status_q <= res_status;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_value = rsp_value_q;
	assign rsp.status       = rsp_status_q;

endmodule
`default_nettype wire

// File: sim/tb_sorted_double_ended_queue.sv
`timescale 1ns / 100ps
// Block-level testbench for the sorted double-ended queue.
module tb_sorted_double_ended_queue;
	import sdq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int N_RANDOM     = 1325;
	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 10;    // settle time after the last result
	localparam int LIMIT_CYCLES = 200000;

	// Kind code that the block answers with ok and zero
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	// One expected rsp transaction
	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic [STATUS_W-1:0]       status;
	} rsp_entry_t;

	// One row of the directed stimulus; typed rows carry the answer by hand
	typedef struct {
		logic [KIND_W-1:0]         kind;
		logic signed [VALUE_W-1:0] value;
		bit                        typed;
		logic signed [VALUE_W-1:0] exp_value;
		logic [STATUS_W-1:0]       exp_status;
	} dir_row_t;

	logic clk;
	logic arst_n;

	sdq_req_if req_if ();
	sdq_rsp_if rsp_if ();

	sorted_double_ended_queue #(
		.CAPACITY(DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// Shadow of the block's contents, kept in ascending order
	logic signed [VALUE_W-1:0] shadow_store[$];
	rsp_entry_t                pending_rsp[$];

	int n_errors = 0;
	int n_cycles = 0;
	bit no_idle  = 1'b0;  // both sides run flat out while set
	bit hold_rsp = 1'b0;  // asks the receiver for one long hold-off

	dir_row_t dir_rows[25];

	//--------------------------------------------------------------------
	// Clock, reset, watchdog
	//--------------------------------------------------------------------
	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d results still awaited", $time, pending_rsp.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	//--------------------------------------------------------------------
	// Predictor: applies one req transaction to the shadow store and
	// works out the rsp it must give
	//--------------------------------------------------------------------
	function automatic void sorted_store_op(
		input  logic [KIND_W-1:0]         kind,
		input  logic signed [VALUE_W-1:0] value,
		output logic signed [VALUE_W-1:0] res_value,
		output logic [STATUS_W-1:0]       res_status
	);
		int pos;
		res_value  = '0;
		res_status = ST_OK;
		case (kind)
			KIND_INSERT: begin
				if (shadow_store.size() >= DEPTH) begin
					res_status = ST_FULL;
				end else begin
					// new value goes ahead of any equal or greater entry
					pos = 0;
					while (pos < shadow_store.size() && shadow_store[pos] < value)
						pos++;
					shadow_store.insert(pos, value);
					res_value = value;
				end
			end
			KIND_POP_MIN: begin
				if (shadow_store.size() == 0)
					res_status = ST_EMPTY;
				else
					res_value = shadow_store.pop_front();
			end
			KIND_POP_MAX: begin
				if (shadow_store.size() == 0)
					res_status = ST_EMPTY;
				else
					res_value = shadow_store.pop_back();
			end
			default: ;  // unused code: nothing changes
		endcase
	endfunction

	//--------------------------------------------------------------------
	// Sender: random gaps, then hold the transaction until it is taken.
	// The prediction is made at the accepting edge.
	//--------------------------------------------------------------------
	task automatic send_req(
		input logic [KIND_W-1:0]         kind,
		input logic signed [VALUE_W-1:0] value,
		input bit                        typed,
		input logic signed [VALUE_W-1:0] typed_value,
		input logic [STATUS_W-1:0]       typed_status
	);
		rsp_entry_t                e;
		logic signed [VALUE_W-1:0] p_value;
		logic [STATUS_W-1:0]       p_status;
		while (!no_idle && $urandom_range(0, 99) < 33) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.kind  <= kind;
		req_if.value <= value;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		sorted_store_op(kind, value, p_value, p_status);
		if (typed)
			e = '{typed_value, typed_status};
		else
			e = '{p_value, p_status};
		pending_rsp.push_back(e);
	endtask

	// Mix of full-range, clustered (lots of duplicates), extreme and mid-range values
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			return $urandom;
		else if (sel < 75)
			return int'($urandom_range(0, 16)) - 8;
		else if (sel < 90) begin
			case ($urandom_range(0, 3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return VAL_MIN + 1;
				default: return VAL_MAX - 1;
			endcase
		end
		return int'($urandom_range(0, 2000)) - 1000;
	endfunction

	//--------------------------------------------------------------------
	// Receiver: random back-pressure, one long hold-off on request
	//--------------------------------------------------------------------
	initial begin
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_if.ready <= 1'b0;
				// block fills its output register and stops taking req
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= 33);
			end
		end
	end

	//--------------------------------------------------------------------
	// Checker: every rsp transaction against the oldest expectation
	//--------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_entry_t e;
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result, value %0d status %0d",
					$time, rsp_if.result_value, rsp_if.status);
			end else begin
				e = pending_rsp.pop_front();
				if (rsp_if.result_value !== e.value) begin
					n_errors++;
					$display("%0t: result_value mismatch, expected %0d actual %0d",
						$time, e.value, rsp_if.result_value);
				end
				if (rsp_if.status !== e.status) begin
					n_errors++;
					$display("%0t: status mismatch, expected %0d actual %0d",
						$time, e.status, rsp_if.status);
				end
			end
		end
	end

	//--------------------------------------------------------------------
	// Stimulus
	//--------------------------------------------------------------------
	initial begin
		int                        i;
		int                        ins_pct;
		logic [KIND_W-1:0]         k;
		logic signed [VALUE_W-1:0] v;

		// directed: empty store, fill to the top, overflow, both ends,
		// unused code with entries present
		dir_rows = '{
			'{KIND_POP_MIN, 32'sd0,        1'b1, 32'sd0,  ST_EMPTY},
			'{KIND_POP_MAX, 32'sd0,        1'b1, 32'sd0,  ST_EMPTY},
			'{KIND_UNUSED,  VAL_MAX,       1'b1, 32'sd0,  ST_OK},
			'{KIND_INSERT,  VAL_MIN,       1'b1, VAL_MIN, ST_OK},
			'{KIND_INSERT,  VAL_MAX,       1'b1, VAL_MAX, ST_OK},
			'{KIND_INSERT,  32'sd0,        1'b1, 32'sd0,  ST_OK},
			'{KIND_INSERT,  -32'sd1,       1'b1, -32'sd1, ST_OK},
			'{KIND_INSERT,  32'sd1,        1'b1, 32'sd1,  ST_OK},
			'{KIND_INSERT,  32'sd5,        1'b1, 32'sd5,  ST_OK},
			'{KIND_INSERT,  32'sd5,        1'b1, 32'sd5,  ST_OK},
			'{KIND_INSERT,  -32'sd5,       1'b1, -32'sd5, ST_OK},
			'{KIND_INSERT,  32'sd100,      1'b1, 32'sd100, ST_OK},
			'{KIND_INSERT,  -32'sd100,     1'b1, -32'sd100, ST_OK},
			'{KIND_INSERT,  32'sh5555_5555, 1'b1, 32'sh5555_5555, ST_OK},
			'{KIND_INSERT,  32'shAAAA_AAAA, 1'b1, 32'shAAAA_AAAA, ST_OK},
			'{KIND_INSERT,  32'sd7,        1'b1, 32'sd7,  ST_OK},
			'{KIND_INSERT,  32'sd7,        1'b1, 32'sd7,  ST_OK},
			'{KIND_INSERT,  -32'sd7,       1'b1, -32'sd7, ST_OK},
			'{KIND_INSERT,  32'sd1000,     1'b1, 32'sd1000, ST_OK},
			'{KIND_INSERT,  32'sd42,       1'b1, 32'sd0,  ST_FULL},
			'{KIND_POP_MAX, 32'sd0,        1'b1, VAL_MAX, ST_OK},
			'{KIND_POP_MIN, 32'sd0,        1'b1, VAL_MIN, ST_OK},
			'{KIND_UNUSED,  32'sd123,      1'b1, 32'sd0,  ST_OK},
			'{KIND_POP_MIN, 32'sd0,        1'b0, 32'sd0,  ST_OK},
			'{KIND_POP_MAX, 32'sd0,        1'b0, 32'sd0,  ST_OK}
		};

		req_if.valid <= 1'b0;
		req_if.kind  <= KIND_INSERT;
		req_if.value <= '0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (dir_rows[r])
			send_req(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].typed,
				dir_rows[r].exp_value, dir_rows[r].exp_status);

		// random: phases leaning towards filling, draining or neither, so
		// that both the full and the empty store are hit again and again
		ins_pct = 50;
		for (i = 0; i < N_RANDOM; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: ins_pct = 75;
					1: ins_pct = 25;
					default: ins_pct = 50;
				endcase
			end
			if (i == 300)
				hold_rsp = 1'b1;  // keep sending through the hold-off
			if (i == 600) begin
				// pause until every result is in
				req_if.valid <= 1'b0;
				while (pending_rsp.size() != 0) @(posedge clk);
			end
			no_idle = (i >= 800 && i < 1000);

			if ($urandom_range(0, 99) < 3)
				k = KIND_UNUSED;
			else if ($urandom_range(0, 99) < ins_pct)
				k = KIND_INSERT;
			else if ($urandom_range(0, 1) == 0)
				k = KIND_POP_MIN;
			else
				k = KIND_POP_MAX;
			v = pick_value();
			send_req(k, v, 1'b0, '0, ST_OK);
		end
		req_if.valid <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
